/* rtl/cdps_pkg.sv */
// ----------------------------------------------------------------------------
// cdps_pkg
// Shared widths, state types and status struct of the drain prefix search.
// ----------------------------------------------------------------------------
package cdps_pkg;

  localparam int VALUE_W         = 40;
  localparam int CAP_W           = 32;
  localparam int REMAIN_W        = 11;
  localparam int DEF_MAX_ENTRIES = 1024;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } top_state_t;

  typedef enum logic [1:0] {
    SRCH_IDLE,
    SRCH_RUN,
    SRCH_DONE
  } srch_state_t;

  // status of the search unit towards the control
  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

endpackage

/* rtl/cdps_prefix_ram.sv */
// ----------------------------------------------------------------------------
// cdps_prefix_ram
// Prefix sum store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cdps_prefix_ram #(
  parameter int DEPTH  = cdps_pkg::DEF_MAX_ENTRIES,
  parameter int DATA_W = 42
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/cdps_search.sv */
// ----------------------------------------------------------------------------
// cdps_search
// Upper-bound binary search over the prefix store, one memory read per step.
// ----------------------------------------------------------------------------
module cdps_search #(
  parameter int MAX_ENTRIES = cdps_pkg::DEF_MAX_ENTRIES,
  parameter int PREFIX_W    = 42,
  parameter int TOTAL_W     = 43
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [TOTAL_W-1:0]                 limit,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]   count,
  output logic                               rd_en,
  output logic [$clog2(MAX_ENTRIES)-1:0]     rd_addr,
  input  logic [PREFIX_W-1:0]                rd_data,
  output cdps_pkg::srch_stat_t               stat,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]   idx
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = $clog2(MAX_ENTRIES);

  cdps_pkg::srch_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  mid_r, mid_nxt;
  logic [TOTAL_W-1:0] limit_r, limit_nxt;

  logic             gt;
  logic [CNT_W-1:0] lo_step;
  logic [CNT_W-1:0] hi_step;
  logic [CNT_W-1:0] mid_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdps_pkg::SRCH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    cnt_r   <= cnt_nxt;
    mid_r   <= mid_nxt;
    limit_r <= limit_nxt;
  end

  always_comb begin
    // rd_data belongs to mid_r while running
    gt       = TOTAL_W'(rd_data) > limit_r;
    lo_step  = gt ? lo_r : (CNT_W'(mid_r) + CNT_W'(1));
    hi_step  = gt ? CNT_W'(mid_r) : hi_r;
    mid_step = lo_step + ((hi_step - lo_step) >> 1);

    state_nxt  = state_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    cnt_nxt    = cnt_r;
    mid_nxt    = mid_r;
    limit_nxt  = limit_r;
    rd_en      = 1'b0;
    rd_addr    = mid_r;
    stat.done  = 1'b0;
    stat.found = lo_r < cnt_r;

    case (state_r)
      cdps_pkg::SRCH_IDLE: begin
        if (start) begin
          lo_nxt    = '0;
          hi_nxt    = count;
          cnt_nxt   = count;
          limit_nxt = limit;
          mid_nxt   = ADDR_W'(count >> 1);
          if (count == '0) begin
            state_nxt = cdps_pkg::SRCH_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ADDR_W'(count >> 1);
            state_nxt = cdps_pkg::SRCH_RUN;
          end
        end
      end
      cdps_pkg::SRCH_RUN: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step < hi_step) begin
          mid_nxt = mid_step[ADDR_W-1:0];
          rd_en   = 1'b1;
          rd_addr = mid_step[ADDR_W-1:0];
        end else begin
          state_nxt = cdps_pkg::SRCH_DONE;
        end
      end
      cdps_pkg::SRCH_DONE: begin
        stat.done = 1'b1;
        state_nxt = cdps_pkg::SRCH_IDLE;
      end
      default: begin
        state_nxt = cdps_pkg::SRCH_IDLE;
      end
    endcase
  end

  assign idx = lo_r;

endmodule

/* rtl/cumulative_drain_prefix_search.sv */
// ----------------------------------------------------------------------------
// cumulative_drain_prefix_search
// Bucket list with running prefix sums and a drain counter.
// ----------------------------------------------------------------------------
// A load request appends a bucket (low 32 bits of in_value) and writes the new
// prefix sum into the prefix store in the cycle it is accepted; loads into a
// full store are dropped and give no result. A query request adds in_value to
// the consumed total and runs an upper-bound binary search over the stored
// prefix sums, one store read per step, so a query holds the input until its
// result is put into the output register; the steps form a serial chain of
// dependent reads on the single store read port. One request is in work at
// a time; a finished result sits in the output register while the next
// request is taken. The store has no reset and needs no clearing pass: only
// entries below the bucket count are read.
// ----------------------------------------------------------------------------
module cumulative_drain_prefix_search #(
  parameter int MAX_ENTRIES = cdps_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [cdps_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cdps_pkg::REMAIN_W-1:0] out_remaining,
  output logic                          out_wrapped
);

  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W   = $clog2(MAX_ENTRIES);
  localparam int PREFIX_W = cdps_pkg::CAP_W + ADDR_W;
  localparam int TOTAL_W  =
    ((PREFIX_W > cdps_pkg::VALUE_W) ? PREFIX_W : cdps_pkg::VALUE_W) + 1;

  cdps_pkg::top_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TOTAL_W-1:0]  consumed_r, consumed_nxt;
  logic [PREFIX_W-1:0] last_prefix_r, last_prefix_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [cdps_pkg::REMAIN_W-1:0] out_remaining_r, out_remaining_nxt;
  logic                          out_wrapped_r, out_wrapped_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic [TOTAL_W-1:0]   total_now;
  logic [PREFIX_W-1:0]  load_sum;
  logic                 wr_en;
  logic                 srch_start;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [PREFIX_W-1:0]  rd_data;
  cdps_pkg::srch_stat_t srch_stat;
  logic [CNT_W-1:0]     srch_idx;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign total_now = consumed_r + TOTAL_W'(in_value);
  assign load_sum  = last_prefix_r + PREFIX_W'(in_value[cdps_pkg::CAP_W-1:0]);

  cdps_prefix_ram #(
    .DEPTH  (MAX_ENTRIES),
    .DATA_W (PREFIX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (load_sum),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cdps_search #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PREFIX_W    (PREFIX_W),
    .TOTAL_W     (TOTAL_W)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (srch_start),
    .limit   (total_now),
    .count   (count_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (srch_stat),
    .idx     (srch_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cdps_pkg::ST_IDLE;
      count_r       <= '0;
      consumed_r    <= '0;
      last_prefix_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      consumed_r    <= consumed_nxt;
      last_prefix_r <= last_prefix_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r         <= total_nxt;
    out_remaining_r <= out_remaining_nxt;
    out_wrapped_r   <= out_wrapped_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    consumed_nxt      = consumed_r;
    last_prefix_nxt   = last_prefix_r;
    total_nxt         = total_r;
    out_remaining_nxt = out_remaining_r;
    out_wrapped_nxt   = out_wrapped_r;
    out_valid_nxt     = out_valid_r && out_stall;
    in_stall          = 1'b1;
    wr_en             = 1'b0;
    srch_start        = 1'b0;

    case (state_r)
      cdps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_accept) begin
          if (in_command == cdps_pkg::CMD_LOAD) begin
            // full store drops the load
            if (count_r < CNT_W'(MAX_ENTRIES)) begin
              wr_en           = 1'b1;
              last_prefix_nxt = load_sum;
              count_nxt       = count_r + CNT_W'(1);
            end
          end else begin
            srch_start = 1'b1;
            total_nxt  = total_now;
            state_nxt  = cdps_pkg::ST_SEARCH;
          end
        end
      end
      cdps_pkg::ST_SEARCH: begin
        if (srch_stat.done) begin
          state_nxt = cdps_pkg::ST_RESULT;
        end
      end
      cdps_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (srch_stat.found) begin
            out_remaining_nxt = cdps_pkg::REMAIN_W'(count_r - srch_idx);
            out_wrapped_nxt   = 1'b0;
            consumed_nxt      = total_r;
          end else begin
            // every bucket drained: report all and restart the total
            out_remaining_nxt = cdps_pkg::REMAIN_W'(count_r);
            out_wrapped_nxt   = 1'b1;
            consumed_nxt      = '0;
          end
          state_nxt = cdps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdps_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_remaining = out_remaining_r;
  assign out_wrapped   = out_wrapped_r;

endmodule

/* tb/drain_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drain_search_checker
// Watches both channels of the drain prefix search and checks every result.
// ----------------------------------------------------------------------------
// Keeps its own bucket list, prefix sums and drained total, updated on every
// accepted request. Each query queues the remaining count and wrap flag it
// should produce; each accepted result is compared with the oldest of them.
// ----------------------------------------------------------------------------
module drain_search_checker #(
  parameter int MAX_ENTRIES = cdps_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_command,
  input  logic [cdps_pkg::VALUE_W-1:0]  in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [cdps_pkg::REMAIN_W-1:0] out_remaining,
  input  logic                          out_wrapped,
  output int                            fail_count,
  output int                            pending_results
);

  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    logic [cdps_pkg::REMAIN_W-1:0] remaining;
    logic                          wrapped;
  } drain_result_t;

  logic [41:0]   prefix_sums [MAX_ENTRIES];
  int unsigned   bucket_count;
  logic [47:0]   drained_total;
  drain_result_t expected_drains [EXP_DEPTH];
  int unsigned   exp_head;
  int unsigned   exp_tail;

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic apply_request(input logic cmd,
                               input logic [cdps_pkg::VALUE_W-1:0] val);
    logic [47:0]   total;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    drain_result_t res;
    if (cmd == cdps_pkg::CMD_LOAD) begin
      // full store drops the load, only the low 32 bits count
      if (bucket_count < MAX_ENTRIES) begin
        prefix_sums[bucket_count] = (bucket_count == 0 ? 42'd0 : prefix_sums[bucket_count - 1])
                                    + 42'(val[cdps_pkg::CAP_W-1:0]);
        bucket_count++;
      end
    end else begin
      total = drained_total + 48'(val);
      lo    = 0;
      hi    = bucket_count;
      // first bucket whose prefix sum is above the drained total
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (48'(prefix_sums[mid]) > total) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      if (lo >= bucket_count) begin
        res.remaining = cdps_pkg::REMAIN_W'(bucket_count);
        res.wrapped   = 1'b1;
        drained_total = '0;
      end else begin
        res.remaining = cdps_pkg::REMAIN_W'(bucket_count - lo);
        res.wrapped   = 1'b0;
        drained_total = total;
      end
      expected_drains[exp_tail % EXP_DEPTH] = res;
      exp_tail++;
    end
  endtask

  always @(posedge clk) begin
    drain_result_t want;
    if (!rst_n) begin
      bucket_count  = 0;
      drained_total = '0;
      exp_head      = 0;
      exp_tail      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_tail == exp_head) begin
          report_mismatch("result with no query pending, remaining",
                          32'(out_remaining), 0);
        end else begin
          want = expected_drains[exp_head % EXP_DEPTH];
          exp_head++;
          if (out_remaining !== want.remaining) begin
            report_mismatch("remaining", 32'(out_remaining), 32'(want.remaining));
          end
          if (out_wrapped !== want.wrapped) begin
            report_mismatch("wrapped", 32'(out_wrapped), 32'(want.wrapped));
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_command, in_value);
      end
    end
    pending_results = int'(exp_tail - exp_head);
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the cumulative drain prefix search.
// ----------------------------------------------------------------------------
// A short directed run covers the empty list, zero and oversized capacities,
// exact prefix boundaries and wraps. Random loads and queries then fill the
// store to the top, push a few loads past it and keep querying. Both sides
// idle at random; the receiver also holds off once for a long stretch so the
// block backs up into its input. The checker counts the mismatches.
// ----------------------------------------------------------------------------
module testbench;

  localparam int BUCKETS      = cdps_pkg::DEF_MAX_ENTRIES;
  localparam int RANDOM_ITEMS = 1150;
  localparam int LATE_QUERIES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_command;
  logic [cdps_pkg::VALUE_W-1:0]  in_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [cdps_pkg::REMAIN_W-1:0] out_remaining;
  logic                          out_wrapped;

  int          fail_count;
  int          pending_results;
  int          cycles;
  int          counted;
  int          late_queries;
  int          loads_taken;
  logic [63:0] loaded_sum;
  bit          tx_quiet;
  bit          hold_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cumulative_drain_prefix_search #(
    .MAX_ENTRIES(BUCKETS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_remaining(out_remaining),
    .out_wrapped  (out_wrapped)
  );

  drain_search_checker #(
    .MAX_ENTRIES(BUCKETS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_remaining  (out_remaining),
    .out_wrapped    (out_wrapped),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(input logic cmd,
                              input logic [cdps_pkg::VALUE_W-1:0] val);
    while (!tx_quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic load_bucket(input logic [cdps_pkg::VALUE_W-1:0] val);
    if (loads_taken < BUCKETS) begin
      loaded_sum += 64'(val[cdps_pkg::CAP_W-1:0]);
      loads_taken++;
    end
    send_request(cdps_pkg::CMD_LOAD, val);
  endtask

  function automatic logic [63:0] rand_upto(input logic [63:0] lim);
    if (lim == 0) begin
      return 64'd0;
    end
    return {$urandom, $urandom} % (lim + 1);
  endfunction

  function automatic logic [cdps_pkg::VALUE_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 40'h00_FFFF_FFFF;
      2:       return {8'($urandom_range(1, 255)), 32'($urandom)};
      3, 4:    return 40'($urandom_range(0, 1000));
      default: return 40'($urandom);
    endcase
  endfunction

  // drains sized against what has been loaded so queries land all over the list
  function automatic logic [cdps_pkg::VALUE_W-1:0] pick_drain(input logic [63:0] span);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {8'($urandom), 32'($urandom)};
      3:       return 40'($urandom_range(0, 255));
      4, 5:    return 40'(rand_upto(span / 64));
      default: return 40'(rand_upto(span / 8));
    endcase
  endfunction

  // receiver: random stalls, one quiet window, one long hold-off
  initial begin
    int rx_cycles;
    int hold_left;
    bit hold_done;
    rx_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_cycles >= 1500 && rx_cycles < 2500) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 16);
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = cdps_pkg::CMD_LOAD;
    in_value     = '0;
    tx_quiet     = 1'b0;
    hold_req     = 1'b0;
    counted      = 0;
    late_queries = 0;
    loads_taken  = 0;
    loaded_sum   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list always wraps
    send_request(cdps_pkg::CMD_QUERY, '0);
    send_request(cdps_pkg::CMD_QUERY, '1);
    // zero capacity gives a repeated prefix sum
    load_bucket(40'd10);
    load_bucket(40'd0);
    load_bucket(40'd20);
    send_request(cdps_pkg::CMD_QUERY, 40'd0);
    send_request(cdps_pkg::CMD_QUERY, 40'd9);
    // total lands exactly on a prefix sum, those buckets count as drained
    send_request(cdps_pkg::CMD_QUERY, 40'd1);
    send_request(cdps_pkg::CMD_QUERY, 40'd19);
    send_request(cdps_pkg::CMD_QUERY, 40'd1);
    send_request(cdps_pkg::CMD_QUERY, 40'd30);
    // oversized capacities keep the low 32 bits only
    load_bucket(40'hFF_FFFF_FFFF);
    load_bucket(40'hAB_0000_0005);
    send_request(cdps_pkg::CMD_QUERY, '1);
    send_request(cdps_pkg::CMD_QUERY, 40'd4294967324);
    send_request(cdps_pkg::CMD_QUERY, 40'd5);
    send_request(cdps_pkg::CMD_QUERY, 40'd1);
    send_request(cdps_pkg::CMD_QUERY, 40'd0);

    // loads past a full store are ignored and not counted
    while (counted < RANDOM_ITEMS || loads_taken < BUCKETS || late_queries < LATE_QUERIES) begin
      tx_quiet = (counted >= 500 && counted < 700);
      if (counted >= 300) begin
        hold_req = 1'b1;
      end
      if ($urandom_range(0, 99) < (loads_taken < BUCKETS ? 88 : 10)) begin
        if (loads_taken < BUCKETS) begin
          counted++;
        end
        load_bucket(pick_capacity());
      end else begin
        counted++;
        if (loads_taken >= BUCKETS) begin
          late_queries++;
        end
        send_request(cdps_pkg::CMD_QUERY, pick_drain(loaded_sum));
      end
    end

    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cdps_pkg.sv
rtl/cdps_prefix_ram.sv
rtl/cdps_search.sv
rtl/cumulative_drain_prefix_search.sv
tb/drain_search_checker.sv
tb/testbench.sv
